// ----- sv/sxfb_pkg.sv -----
// Shared types, constants and helper functions for the sprite XOR framebuffer.
// No dependencies; every other file of the block refers to this package by scoped names.
package sxfb_pkg;

  localparam int SCREEN_COLS  = 64;
  localparam int SCREEN_LINES = 32;
  localparam int SPRITE_WIDTH = 8;
  localparam int SPRITE_MSB   = SPRITE_WIDTH - 1;
  localparam int COL_AW       = $clog2(SCREEN_COLS);
  localparam int LINE_AW      = $clog2(SCREEN_LINES);

  typedef logic [SCREEN_COLS-1:0] line_t;
  typedef logic [LINE_AW-1:0]     line_addr_t;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_DRAW  = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } fsm_t;

  typedef struct packed {
    logic       wr_en;
    logic       clr_all;
    line_addr_t wr_addr;
  } store_ctl_t;

  function automatic line_addr_t line_of(input logic [7:0] y_origin,
                                         input logic [3:0] row_index);
    logic [8:0] sum;
    sum = {1'b0, y_origin} + {5'd0, row_index};
    return sum[LINE_AW-1:0];
  endfunction

  function automatic line_t sprite_mask(input logic [7:0] x_origin,
                                        input logic [7:0] sprite_byte);
    line_t            mask;
    logic [COL_AW-1:0] col;
    mask = '0;
    for (int c = 0; c < SPRITE_WIDTH; c++) begin
      col = x_origin[COL_AW-1:0] + COL_AW'(c);
      if (sprite_byte[SPRITE_MSB - c]) begin
        mask[col] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage

// ----- sv/sxfb_line_store.sv -----
// Framebuffer line memory with registered read and per-line valid bits.
// Depends on sxfb_pkg for the line type, address type and the write control struct.
module sxfb_line_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  sxfb_pkg::line_addr_t  rd_addr,
  output sxfb_pkg::line_t       rd_data,
  input  sxfb_pkg::store_ctl_t  ctl,
  input  sxfb_pkg::line_t       wr_data
);

  sxfb_pkg::line_t                    mem [sxfb_pkg::SCREEN_LINES];
  logic [sxfb_pkg::SCREEN_LINES-1:0]  valid_r;
  sxfb_pkg::line_t                    rd_data_r;
  logic                               rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ----- sv/sxfb_row_merge.sv -----
// XOR merge of one sprite row into a framebuffer line, with collision detection.
// Depends on sxfb_pkg for the line type and the sprite mask function.
module sxfb_row_merge (
  input  sxfb_pkg::line_t  old_line,
  input  logic [7:0]       x_origin,
  input  logic [7:0]       sprite_byte,
  output sxfb_pkg::line_t  new_line,
  output logic             hit
);

  sxfb_pkg::line_t mask;

  assign mask     = sxfb_pkg::sprite_mask(x_origin, sprite_byte);
  assign new_line = old_line ^ mask;
  assign hit      = |(old_line & mask);

endmodule

// ----- sv/sprite_xor_framebuffer.sv -----
// Top level of the sprite XOR framebuffer: command sequencer, collision flag and result register.
// Depends on sxfb_pkg, sxfb_line_store and sxfb_row_merge.
//
// For each command, the cycle of acceptance reads the target line from the line memory, and
// the next cycle merges the sprite row and writes the line back, so busy is high for one
// cycle after every accepted word. The result word appears on the out_ ports with out_strobe
// high in the cycle after that, for exactly one cycle; the receiver cannot stall it. A clear
// command follows the same sequence and needs no pass over the lines, since it only drops the
// per-line valid bits. The framebuffer is blank right after reset with no clearing pass.
module sprite_xor_framebuffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [7:0] in_x_origin,
  input  logic [7:0] in_y_origin,
  input  logic [3:0] in_row_index,
  input  logic [7:0] in_sprite_byte,
  input  logic       in_first_row,
  input  logic       in_last_row,
  output logic       out_strobe,
  output logic       out_collision,
  output logic       out_done_res
);

  sxfb_pkg::fsm_t        state_r, state_nxt;
  logic                  accept;
  sxfb_pkg::line_addr_t  rd_addr;
  sxfb_pkg::line_t       old_line, new_line;
  sxfb_pkg::store_ctl_t  ctl;
  logic                  merge_hit;

  sxfb_pkg::cmd_t        pend_cmd_r;
  logic [7:0]            pend_x_r;
  logic [7:0]            pend_byte_r;
  logic                  pend_first_r;
  logic                  pend_last_r;
  sxfb_pkg::line_addr_t  pend_line_r;

  logic                  hit_r, hit_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic                  out_collision_r, out_collision_nxt;
  logic                  out_done_res_r, out_done_res_nxt;

  assign accept  = start && !busy;
  assign rd_addr = sxfb_pkg::line_of(in_y_origin, in_row_index);

  always_comb begin
    unique case (state_r)
      sxfb_pkg::ST_IDLE:  state_nxt = accept ? sxfb_pkg::ST_MERGE : sxfb_pkg::ST_IDLE;
      sxfb_pkg::ST_MERGE: state_nxt = sxfb_pkg::ST_IDLE;
      default:            state_nxt = sxfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy              = 1'b0;
    ctl               = '0;
    ctl.wr_addr       = pend_line_r;
    hit_nxt           = hit_r;
    out_strobe_nxt    = 1'b0;
    out_collision_nxt = out_collision_r;
    out_done_res_nxt  = out_done_res_r;
    unique case (state_r)
      sxfb_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      sxfb_pkg::ST_MERGE: begin
        busy           = 1'b1;
        out_strobe_nxt = 1'b1;
        if (pend_cmd_r == sxfb_pkg::CMD_CLEAR) begin
          ctl.clr_all       = 1'b1;
          out_collision_nxt = hit_r;
          out_done_res_nxt  = 1'b1;
        end else begin
          ctl.wr_en         = 1'b1;
          hit_nxt           = (hit_r && !pend_first_r) || merge_hit;
          out_collision_nxt = hit_nxt;
          out_done_res_nxt  = pend_last_r;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sxfb_pkg::ST_IDLE;
      hit_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hit_r        <= hit_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_collision_r <= out_collision_nxt;
    out_done_res_r  <= out_done_res_nxt;
    if (accept) begin
      pend_cmd_r   <= sxfb_pkg::cmd_t'(in_cmd);
      pend_x_r     <= in_x_origin;
      pend_byte_r  <= in_sprite_byte;
      pend_first_r <= in_first_row;
      pend_last_r  <= in_last_row;
      pend_line_r  <= rd_addr;
    end
  end

  sxfb_line_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (old_line),
    .ctl     (ctl),
    .wr_data (new_line)
  );

  sxfb_row_merge u_merge (
    .old_line    (old_line),
    .x_origin    (pend_x_r),
    .sprite_byte (pend_byte_r),
    .new_line    (new_line),
    .hit         (merge_hit)
  );

  assign out_strobe    = out_strobe_r;
  assign out_collision = out_collision_r;
  assign out_done_res  = out_done_res_r;

  a_strobe_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == sxfb_pkg::ST_MERGE))
    else $error("result strobe without a preceding merge cycle");

  a_merge_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sxfb_pkg::ST_MERGE |=> state_r == sxfb_pkg::ST_IDLE)
    else $error("merge state held for more than one cycle");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && $past(pend_cmd_r == sxfb_pkg::CMD_CLEAR)
      |-> out_done_res_r && (out_collision_r == $past(hit_r)))
    else $error("clear result does not report the unchanged collision flag");

endmodule
